// ===== rtl/mi3_pkg.sv =====
// mi3_pkg: widths and latency constants for the 3x3 matrix inverse.
// Used by mi3_div_lane and matrix_inverse_3x3; depends on nothing.
package mi3_pkg;

  localparam int ELEM_W  = 16;  // Q8.8 input element
  localparam int PROD_W  = 32;  // element product
  localparam int COF_W   = 33;  // cofactor, Q16.16 exact
  localparam int DPROD_W = ELEM_W + COF_W;  // first-row term of det
  localparam int DET_W   = DPROD_W + 3;     // det sum with headroom
  localparam int DEN_W   = 49;  // |det|, 24 fraction bits
  localparam int THR_W   = 40;  // threshold register
  localparam int CMAG_W  = 32;  // |cofactor|
  localparam int FRAC_SH = 24;  // numerator scaling
  localparam int NUM_W   = CMAG_W + FRAC_SH + 1;  // scaled numerator plus rounding
  localparam int Q_W     = 33;  // quotient bits developed
  localparam int OUT_W   = 32;  // Q16.16 result
  localparam int CMP_W   = DEN_W + Q_W;  // widest shifted divisor
  localparam int DIV_LAT = Q_W + 2;      // divider: setup, one bit per stage, format

endpackage

// ===== rtl/mi3_div_lane.sv =====
// mi3_div_lane: pipelined restoring divider for one inverse element,
// one quotient bit per stage, sign and saturation at the end. Uses mi3_pkg.
module mi3_div_lane (
  input  logic                            clk,
  input  logic [mi3_pkg::NUM_W-1:0]       num,
  input  logic [mi3_pkg::DEN_W-1:0]       den,
  input  logic                            neg,
  input  logic                            zero,
  output logic [mi3_pkg::OUT_W-1:0]       quo
);

  localparam int NSTG = mi3_pkg::Q_W;

  logic [mi3_pkg::NUM_W-1:0] rem  [0:NSTG];
  logic [mi3_pkg::DEN_W-1:0] dv   [0:NSTG];
  logic [mi3_pkg::Q_W-1:0]   qacc [0:NSTG];
  logic                      ng   [0:NSTG];
  logic                      zr   [0:NSTG];
  logic                      ov   [0:NSTG];

  // Setup stage: flag a quotient of 2^33 or more
  always_ff @(posedge clk) begin
    rem[0]  <= num;
    dv[0]   <= den;
    qacc[0] <= '0;
    ng[0]   <= neg;
    zr[0]   <= zero;
    ov[0]   <= (mi3_pkg::CMP_W'(num) >= (mi3_pkg::CMP_W'(den) << mi3_pkg::Q_W));
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    localparam int K = NSTG - s;
    logic [mi3_pkg::CMP_W-1:0] sh;
    logic                      ge;
    assign sh = mi3_pkg::CMP_W'(dv[s-1]) << K;
    assign ge = (mi3_pkg::CMP_W'(rem[s-1]) >= sh);
    always_ff @(posedge clk) begin
      rem[s]  <= ge ? mi3_pkg::NUM_W'(mi3_pkg::CMP_W'(rem[s-1]) - sh) : rem[s-1];
      qacc[s] <= {qacc[s-1][mi3_pkg::Q_W-2:0], ge};
      dv[s]   <= dv[s-1];
      ng[s]   <= ng[s-1];
      zr[s]   <= zr[s-1];
      ov[s]   <= ov[s-1];
    end
  end

  // Force zero, or apply sign and saturate
  logic [mi3_pkg::Q_W-1:0]   qf;
  logic [mi3_pkg::OUT_W-1:0] res;
  assign qf = qacc[NSTG];
  always_comb begin
    priority if (zr[NSTG]) begin
      res = '0;
    end else if (ng[NSTG]) begin
      if (ov[NSTG] || qf > {1'b0, 1'b1, {(mi3_pkg::Q_W-2){1'b0}}})
        res = {1'b1, {(mi3_pkg::OUT_W-1){1'b0}}};
      else
        res = mi3_pkg::OUT_W'(~qf + 1'b1);
    end else begin
      if (ov[NSTG] || qf > {2'b00, {(mi3_pkg::Q_W-2){1'b1}}})
        res = {1'b0, {(mi3_pkg::OUT_W-1){1'b1}}};
      else
        res = qf[mi3_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo <= res;
  end

endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
// matrix_inverse_3x3: adjugate 3x3 inverse, Q8.8 in, Q16.16 out, singular test.
// Depends on mi3_pkg and mi3_div_lane (nine lanes).
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start / busy         | m00 .. m22, 16 bit signed
//  result   | done (one cycle)     | inv00 .. inv22, singular
//  config   | cfg_valid/cfg_ready  | cfg_data, det_threshold
//
// One matrix can enter every cycle; busy stays low. The pipeline has five
// stages of products, cofactors, det terms, det and threshold test, divider
// setup, then 35 in the divider (setup, one quotient bit per stage, output).
// Synchronous reset clears the valid chain and the threshold to zero.
// The receiver cannot stall, so the pipeline never holds.
module matrix_inverse_3x3 (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic                done,
  output logic signed [31:0]  inv00, inv01, inv02, inv10, inv11, inv12,
  output logic signed [31:0]  inv20, inv21, inv22,
  output logic                singular,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [39:0]         cfg_data
);

  localparam int LAT = mi3_pkg::DIV_LAT;

  logic [mi3_pkg::THR_W-1:0] det_threshold;
  logic v1, v2, v3, v4, v5;
  logic [LAT-1:0] vch, sch;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      det_threshold <= cfg_data;
    end
  end

  // Stage 1: element products, cofactor i = pa[i] - pb[i]
  logic signed [mi3_pkg::PROD_W-1:0] pa [0:8];
  logic signed [mi3_pkg::PROD_W-1:0] pb [0:8];
  logic signed [mi3_pkg::ELEM_W-1:0] r0a [0:2];
  always_ff @(posedge clk) begin
    pa[0] <= m11 * m22;  pb[0] <= m12 * m21;
    pa[1] <= m21 * m02;  pb[1] <= m01 * m22;
    pa[2] <= m01 * m12;  pb[2] <= m11 * m02;
    pa[3] <= m20 * m12;  pb[3] <= m10 * m22;
    pa[4] <= m00 * m22;  pb[4] <= m20 * m02;
    pa[5] <= m10 * m02;  pb[5] <= m00 * m12;
    pa[6] <= m10 * m21;  pb[6] <= m20 * m11;
    pa[7] <= m20 * m01;  pb[7] <= m00 * m21;
    pa[8] <= m00 * m11;  pb[8] <= m01 * m10;
    r0a[0] <= m00;
    r0a[1] <= m01;
    r0a[2] <= m02;
  end

  // Stage 2: cofactors
  logic signed [mi3_pkg::COF_W-1:0]  cof2 [0:8];
  logic signed [mi3_pkg::ELEM_W-1:0] r0b  [0:2];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++)
      cof2[i] <= mi3_pkg::COF_W'(pa[i]) - mi3_pkg::COF_W'(pb[i]);
    for (int j = 0; j < 3; j++)
      r0b[j] <= r0a[j];
  end

  // Stage 3: first-row terms of the determinant
  logic signed [mi3_pkg::COF_W-1:0]   cof3 [0:8];
  logic signed [mi3_pkg::DPROD_W-1:0] dp   [0:2];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++)
      cof3[i] <= cof2[i];
    for (int j = 0; j < 3; j++)
      dp[j] <= r0b[j] * cof2[3*j];
  end

  // Stage 4: determinant, magnitude and singular test
  logic signed [mi3_pkg::DET_W-1:0] det_c;
  logic [mi3_pkg::DET_W-1:0]        det_abs;
  logic [mi3_pkg::DEN_W-1:0]        dmag4;
  logic                             dneg4, sing4;
  logic signed [mi3_pkg::COF_W-1:0] cof4 [0:8];
  assign det_c   = mi3_pkg::DET_W'(dp[0]) + mi3_pkg::DET_W'(dp[1])
                 + mi3_pkg::DET_W'(dp[2]);
  assign det_abs = det_c[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det_c) : det_c;
  always_ff @(posedge clk) begin
    dmag4 <= det_abs[mi3_pkg::DEN_W-1:0];
    dneg4 <= det_c[mi3_pkg::DET_W-1];
    sing4 <= (det_abs <= mi3_pkg::DET_W'({det_threshold, 8'h00}));
    for (int i = 0; i < 9; i++)
      cof4[i] <= cof3[i];
  end

  // Stage 5: divider operands with half-divisor rounding bias
  logic [mi3_pkg::NUM_W-1:0] num5 [0:8];
  logic [mi3_pkg::DEN_W-1:0] den5;
  logic                      neg5 [0:8];
  logic                      zero5 [0:8];
  logic                      sing5;
  logic [mi3_pkg::CMAG_W-1:0] cmag [0:8];
  always_comb begin
    for (int i = 0; i < 9; i++)
      cmag[i] = cof4[i][mi3_pkg::COF_W-1] ? mi3_pkg::CMAG_W'(-cof4[i])
                                          : mi3_pkg::CMAG_W'(cof4[i]);
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      num5[i]  <= mi3_pkg::NUM_W'({cmag[i], {mi3_pkg::FRAC_SH{1'b0}}})
                + mi3_pkg::NUM_W'(dmag4 >> 1);
      neg5[i]  <= cof4[i][mi3_pkg::COF_W-1] ^ dneg4;
      zero5[i] <= (cof4[i] == '0) || sing4;
    end
    den5  <= dmag4;
    sing5 <= sing4;
  end

  // Nine divider lanes
  logic [mi3_pkg::OUT_W-1:0] q [0:8];
  for (genvar g = 0; g < 9; g++) begin : g_lane
    mi3_div_lane u_div (
      .clk  (clk),
      .num  (num5[g]),
      .den  (den5),
      .neg  (neg5[g]),
      .zero (zero5[g]),
      .quo  (q[g])
    );
  end

  // Advance valid bits and the singular flag alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      vch <= '0;
    end else begin
      v1  <= start && !busy;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      vch <= {vch[LAT-2:0], v5};
    end
    sch <= {sch[LAT-2:0], sing5};
  end

  assign done     = vch[LAT-1];
  assign singular = sch[LAT-1];
  assign inv00 = q[0];  assign inv01 = q[1];  assign inv02 = q[2];
  assign inv10 = q[3];  assign inv11 = q[4];  assign inv12 = q[5];
  assign inv20 = q[6];  assign inv21 = q[7];  assign inv22 = q[8];

`ifndef ASSERT_OFF
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> inv00 == 0 && inv11 == 0 && inv22 == 0 && inv01 == 0)
    else $error("singular result carries nonzero elements");
  a_chain: assert property (@(posedge clk) disable iff (rst)
    v5 |=> vch[0])
    else $error("item lost entering divider chain");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    v4 |-> ##(LAT+1) done)
    else $error("result strobe missing after divider latency");
`endif

endmodule

// ===== tb/tb_matrix_inverse_3x3.sv =====
// tb_matrix_inverse_3x3: checks the adjugate 3x3 inverse against a predictor
// in the bench. Depends on matrix_inverse_3x3 and mi3_pkg only.
module tb_matrix_inverse_3x3;

  typedef struct packed {
    logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  } mat_t;

  typedef struct packed {
    logic [8:0][31:0] q;
    logic             sing;
  } inv_t;

  // one row of the directed table; has_exp marks a typed-in answer
  typedef struct {
    mat_t m;
    bit   has_exp;
    inv_t exp_inv;
  } dir_row_t;

  localparam logic [mi3_pkg::THR_W-1:0] THR_MAX = {mi3_pkg::THR_W{1'b1}};
  localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_SAT = 32'h8000_0000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] INV_LSB = 32'h0100_0000;  // inverse of one Q8.8 step

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
  logic signed [15:0] m12 = '0, m20 = '0, m21 = '0, m22 = '0;
  logic done;
  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic singular;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [39:0] cfg_data = '0;

  logic [mi3_pkg::THR_W-1:0] threshold_copy;
  inv_t inverse_queue[$];
  int   n_errors = 0;

  matrix_inverse_3x3 uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .done(done),
    .inv00(inv00), .inv01(inv01), .inv02(inv02), .inv10(inv10), .inv11(inv11),
    .inv12(inv12), .inv20(inv20), .inv21(inv21), .inv22(inv22),
    .singular(singular),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cofactor over det, rounded half away from zero, saturated to Q16.16
  function automatic logic [31:0] div_round(longint cof, longint det);
    logic [127:0] num, den, quo;
    bit neg;
    num = (cof < 0) ? -cof : cof;
    num = num << 24;
    den = (det < 0) ? -det : det;
    neg = (cof < 0) != (det < 0);
    if (cof == 0 || den == 0) return '0;
    quo = (num + den / 2) / den;
    if (neg) begin
      if (quo > 128'h8000_0000) quo = 128'h8000_0000;
      return -quo[31:0];
    end
    if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  function automatic inv_t predict_inverse(mat_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, det, mag;
    longint c[9];
    inv_t r;
    a00 = m.a00; a01 = m.a01; a02 = m.a02;
    a10 = m.a10; a11 = m.a11; a12 = m.a12;
    a20 = m.a20; a21 = m.a21; a22 = m.a22;
    c[0] = a11 * a22 - a12 * a21;
    c[3] = -(a10 * a22 - a20 * a12);
    c[6] = a10 * a21 - a20 * a11;
    c[1] = -(a01 * a22 - a21 * a02);
    c[4] = a00 * a22 - a20 * a02;
    c[7] = -(a00 * a21 - a20 * a01);
    c[2] = a01 * a12 - a11 * a02;
    c[5] = -(a00 * a12 - a10 * a02);
    c[8] = a00 * a11 - a01 * a10;
    det = a00 * c[0] + a01 * c[3] + a02 * c[6];
    mag = (det < 0) ? -det : det;
    r = '0;
    if (mag <= (longint'(threshold_copy) << 8)) begin
      r.sing = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) r.q[8 - i] = div_round(c[i], det);
    return r;
  endfunction

  function automatic inv_t make_inv(logic [31:0] e0, e1, e2, e3, e4, e5, e6, e7, e8,
                                    logic s);
    inv_t r;
    r.q = {e0, e1, e2, e3, e4, e5, e6, e7, e8};
    r.sing = s;
    return r;
  endfunction

  function automatic mat_t make_mat(int v0, v1, v2, v3, v4, v5, v6, v7, v8);
    mat_t m;
    m = {16'(v0), 16'(v1), 16'(v2), 16'(v3), 16'(v4), 16'(v5), 16'(v6),
         16'(v7), 16'(v8)};
    return m;
  endfunction

  // random element: mostly moderate values, sometimes full range
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 1024)) - 16'd512;
      default: return 16'($urandom_range(0, 8192)) - 16'd4096;
    endcase
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // make some rows dependent so singular cases show up
    if ($urandom_range(0, 9) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    inv_t got, want;
    if (!rst && done) begin
      got.q = {inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
      got.sing = singular;
      if (inverse_queue.size() == 0) begin
        $error("result beat with no expectation waiting");
        n_errors++;
      end else begin
        want = inverse_queue.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.q[8 - i] !== want.q[8 - i]) begin
            $error("inv%0d%0d: expected %h, got %h", i / 3, i % 3,
                   want.q[8 - i], got.q[8 - i]);
            n_errors++;
          end
        if (got.sing !== want.sing) begin
          $error("singular: expected %b, got %b", want.sing, got.sing);
          n_errors++;
        end
      end
    end
  end

  task automatic write_threshold(logic [mi3_pkg::THR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold_copy = value;
    cfg_valid <= 1'b0;
  endtask

  // drive one matrix and hold it until accepted; the expectation is queued
  // at the accepting edge. start stays high for the next beat.
  task automatic send_matrix(mat_t m, bit has_exp, inv_t exp_inv);
    inv_t want;
    start <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <= m;
    do @(posedge clk); while (busy);
    want = predict_inverse(m);
    if (has_exp && want !== exp_inv) begin
      $error("table row disagrees with predictor");
      n_errors++;
    end
    inverse_queue.push_back(want);
  endtask

  task automatic drain();
    while (inverse_queue.size() != 0) @(posedge clk);
    repeat (mi3_pkg::DIV_LAT + 10) @(posedge clk);
  endtask

  task automatic gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    dir_row_t table_rows[$];
    inv_t none;
    int burst;
    none = '0;
    threshold_copy = '0;
    // identity, scaled identity, extremes, singular and saturation cases
    table_rows = '{
      '{make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
        make_inv(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
      '{make_mat(256, 0, 0, 0, 256, 0, 0, 0, 256), 1,
        make_inv(ONE_Q16, 0, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16, 0)},
      '{make_mat(-256, 0, 0, 0, -256, 0, 0, 0, -256), 1,
        make_inv(-ONE_Q16, 0, 0, 0, -ONE_Q16, 0, 0, 0, -ONE_Q16, 0)},
      '{make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
        make_inv(INV_LSB, 0, 0, 0, INV_LSB, 0, 0, 0, INV_LSB, 0)},
      '{make_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
        make_inv(-INV_LSB, 0, 0, 0, INV_LSB, 0, 0, 0, INV_LSB, 0)},
      '{make_mat(1, 256, 0, 0, 1, 0, 0, 0, 1), 1,
        make_inv(INV_LSB, NEG_SAT, 0, 0, INV_LSB, 0, 0, 0, INV_LSB, 0)},
      '{make_mat(1, -256, 0, 0, 1, 0, 0, 0, 1), 1,
        make_inv(INV_LSB, POS_SAT, 0, 0, INV_LSB, 0, 0, 0, INV_LSB, 0)},
      '{make_mat(1, 2, 3, 2, 4, 6, 7, 8, 9), 1,
        make_inv(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
      '{make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0, none},
      '{make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 0, none},
      '{make_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                 -32768), 1, make_inv(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)},
      '{make_mat(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767,
                 -32768), 0, none},
      '{make_mat(32767, -32768, 32767, -32768, 32767, -32768, -32768, 0,
                 32767), 0, none},
      '{make_mat(256, 512, 0, 0, 256, 768, 1024, 0, 256), 0, none},
      '{make_mat(3, 0, 0, 0, 3, 0, 0, 0, 3), 0, none},
      '{make_mat(0, 256, 0, 256, 0, 0, 0, 0, 256), 0, none},
      '{make_mat(-1, -1, 0, 1, -1, 0, 0, 0, -1), 0, none}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: walk the table back to back
    foreach (table_rows[i])
      send_matrix(table_rows[i].m, table_rows[i].has_exp, table_rows[i].exp_inv);
    gap(1);
    drain();

    // thresholds: small, then max (max makes everything singular)
    foreach (table_rows[i]) begin
      if (i == 0) write_threshold(40'd1);
      send_matrix(table_rows[i].m, 0, none);
    end
    gap(1);
    drain();
    write_threshold(THR_MAX);
    send_matrix(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1,
                make_inv(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_matrix(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 0, none);
    gap(1);
    drain();

    // random part in phases with different thresholds
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold('0);
        1: write_threshold(40'($urandom_range(1, 4096)));
        2: write_threshold({8'($urandom), 32'($urandom)});
        3: write_threshold(40'($urandom_range(0, 1 << 20)));
        default: write_threshold('0);
      endcase
      for (int n = 0; n < 260; ) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && n < 260; k++, n++)
          send_matrix(rand_mat(), 0, none);
        if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
      end
      gap(1);
      drain();
    end

    if (n_errors == 0)
      $display("tb_matrix_inverse_3x3: clean");
    else
      $display("tb_matrix_inverse_3x3: errors");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb_matrix_inverse_3x3: errors");
    $finish;
  end

endmodule
